// ===== design/mhs_pkg.sv =====
// Package for the markup heading stripper: character codes, default tag capacity
// and the command/status structs between controller and datapath.
// No dependencies.
package mhs_pkg;

	localparam int unsigned MAX_TAG_DEFAULT = 62;

	localparam logic [7:0] CHAR_LT      = 8'h3C; // '<'
	localparam logic [7:0] CHAR_GT      = 8'h3E; // '>'
	localparam logic [7:0] CHAR_HEAD    = 8'h54; // 'T'
	localparam logic [7:0] CHAR_HIDE_ON = 8'h53; // 'S'
	localparam logic [7:0] CHAR_HIDE_OFF = 8'h73; // 's'

	// controller to datapath
	typedef struct packed {
		logic take;        // input transfer this cycle
		logic emit_open;   // load '<' of a replayed tag
		logic emit_body;   // load the next stored tag byte
		logic emit_close;  // load '>' of a replayed tag
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;    // output register can take a result this cycle
		logic replay_req;  // the byte on the input would replay the stored tag
		logic len_zero;    // stored tag is empty
		logic body_last;   // byte being emitted is the last stored byte
	} sts_t;

endpackage

// ===== design/markup_heading_stripper_top.sv =====
// Top level of the markup heading stripper: controller plus datapath.
// Depends on mhs_pkg, mhs_ctrl and mhs_dp.
//
// Filters markup text one byte per transfer. Plain bytes and tags that are
// dropped or buffered are taken while the output register is free. A '>'
// that re-emits a kept tag of N bytes produces N+2 result transfers and holds
// s_tready low while they go out, since the tag store has one read port and
// results leave through one output register; a stalled m_tready stretches
// this further. Configuration goes through cfg_valid/cfg_data, always ready.
module markup_heading_stripper_top #(
	parameter int unsigned MAX_TAG = mhs_pkg::MAX_TAG_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,   // headings_shown
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] text_byte
	input  logic       s_tlast,    // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tlast,    // run_last
	output logic       m_tuser     // [0] tag_truncated
);

	mhs_pkg::cmd_t cmd;
	mhs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhs_dp #(
		.MAX_TAG (MAX_TAG)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== design/mhs_ctrl.sv =====
// Controller of the markup heading stripper: accepts input bytes and sequences
// the replay of a stored tag. Depends on mhs_pkg.
module mhs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mhs_pkg::sts_t sts,
	output mhs_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_OPEN  = 2'd1;
	localparam logic [1:0] ST_BODY  = 2'd2;
	localparam logic [1:0] ST_CLOSE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = sts.out_free;
				cmd.take = s_tvalid & sts.out_free;
				if (cmd.take && sts.replay_req) begin
					state_nx = ST_OPEN;
				end
			end
			ST_OPEN: begin
				if (sts.out_free) begin
					cmd.emit_open = 1'b1;
					state_nx      = sts.len_zero ? ST_CLOSE : ST_BODY;
				end
			end
			ST_BODY: begin
				if (sts.out_free) begin
					cmd.emit_body = 1'b1;
					if (sts.body_last) begin
						state_nx = ST_CLOSE;
					end
				end
			end
			ST_CLOSE: begin
				if (sts.out_free) begin
					cmd.emit_close = 1'b1;
					state_nx       = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== design/mhs_dp.sv =====
// Datapath of the markup heading stripper: filter state, tag store memory,
// replay index and the output register. Depends on mhs_pkg.
module mhs_dp #(
	parameter int unsigned MAX_TAG = mhs_pkg::MAX_TAG_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic          cfg_data,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	input  mhs_pkg::cmd_t cmd,
	output mhs_pkg::sts_t sts,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	output logic          m_tuser
);

	localparam int unsigned AW = $clog2(MAX_TAG);
	localparam int unsigned LW = $clog2(MAX_TAG + 1);

	logic          shown_q;
	logic          inside_q;
	logic          hiding_q;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          end_q;
	logic [7:0]    first0_q;
	logic [7:0]    first1_q;
	logic [LW-1:0] idx_q;
	logic [7:0]    rd_q;
	logic [7:0]    mem [MAX_TAG];

	logic          is_lt;
	logic          is_gt;
	logic          head_tag;
	logic          store_wr;
	logic [LW-1:0] idx_nx;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          out_load;
	logic [7:0]    out_byte;
	logic          out_last;
	logic          out_trunc;
	logic          pass_byte;

	assign is_lt    = (s_tdata == mhs_pkg::CHAR_LT);
	assign is_gt    = (s_tdata == mhs_pkg::CHAR_GT);
	assign head_tag = (len_q != '0) && (first0_q == mhs_pkg::CHAR_HEAD);
	assign store_wr = cmd.take && !shown_q && !is_lt && !is_gt && inside_q
		&& (len_q < LW'(MAX_TAG));
	assign pass_byte = cmd.take && (shown_q || (!is_lt && !is_gt && !inside_q && !hiding_q));

	assign idx_nx  = idx_q + LW'(1);
	assign rd_en   = cmd.emit_open || (cmd.emit_body && (idx_nx != len_q));
	assign rd_addr = cmd.emit_open ? '0 : idx_nx[AW-1:0];

	assign sts.out_free   = !m_tvalid || m_tready;
	assign sts.replay_req = !shown_q && is_gt && !head_tag && !hiding_q;
	assign sts.len_zero   = (len_q == '0);
	assign sts.body_last  = (idx_nx == len_q);

	always_comb begin
		out_load  = pass_byte || cmd.emit_open || cmd.emit_body || cmd.emit_close;
		out_byte  = s_tdata;
		out_last  = 1'b1;
		out_trunc = 1'b0;
		if (cmd.emit_open) begin
			out_byte = mhs_pkg::CHAR_LT;
			out_last = 1'b0;
		end else if (cmd.emit_body) begin
			out_byte = rd_q;
			out_last = 1'b0;
		end else if (cmd.emit_close) begin
			out_byte  = mhs_pkg::CHAR_GT;
			out_trunc = ovf_q;
		end
	end

	// tag store: one write port at the fill position, one registered read port
	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem[len_q[AW-1:0]] <= s_tdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// copies of the first two tag bytes for the heading decode on '>'
	always_ff @(posedge clk) begin
		if (store_wr && len_q == LW'(0)) begin
			first0_q <= s_tdata;
		end
		if (store_wr && len_q == LW'(1)) begin
			first1_q <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= out_byte;
			m_tlast <= out_last;
			m_tuser <= out_trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= 1'b0;
		end else if (cfg_valid) begin
			shown_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.emit_open) begin
			idx_q <= '0;
		end else if (cmd.emit_body) begin
			idx_q <= idx_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			hiding_q <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			end_q    <= 1'b0;
		end else if (cmd.take) begin
			// end of text clears at once unless a replay still needs the tag
			if (s_tlast && !sts.replay_req) begin
				inside_q <= 1'b0;
				hiding_q <= 1'b0;
				len_q    <= '0;
				ovf_q    <= 1'b0;
				end_q    <= 1'b0;
			end else begin
				end_q <= s_tlast;
				if (!shown_q) begin
					if (is_lt) begin
						inside_q <= 1'b1;
						len_q    <= '0;
						ovf_q    <= 1'b0;
					end else if (is_gt) begin
						inside_q <= 1'b0;
						if (head_tag && len_q >= LW'(2)) begin
							if (first1_q == mhs_pkg::CHAR_HIDE_ON) begin
								hiding_q <= 1'b1;
							end else if (first1_q == mhs_pkg::CHAR_HIDE_OFF) begin
								hiding_q <= 1'b0;
							end
						end
					end else if (inside_q) begin
						if (len_q < LW'(MAX_TAG)) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
			end
		end else if (cmd.emit_close && end_q) begin
			inside_q <= 1'b0;
			hiding_q <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			end_q    <= 1'b0;
		end
	end

endmodule
